### hdl/vaq_pkg.sv
// Shared types and constants of the vertex attribute quantizer.
// No dependencies; used by every module of the block.
package vaq_pkg;

  localparam int NUM_REGS   = 6;
  localparam int IDX_W      = 3;
  localparam int NUM_W      = 48;   // divider dividend width
  localparam int DEN_W      = 32;   // divider divisor width (doubled inside)
  localparam int REM_W      = 33;
  localparam int Q_W        = 15;   // quotient magnitude bits
  localparam int DIV_DEPTH  = 16;   // load stage plus one stage per quotient bit
  localparam int NUM_LANES  = 7;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  // divider lanes: three position axes, then normal a/b, tangent a/b
  localparam int LANE_NA = 3;
  localparam int LANE_NB = 4;
  localparam int LANE_TA = 5;
  localparam int LANE_TB = 6;

  localparam logic [15:0] SNORM_MAX = 16'sd32767;
  localparam logic [15:0] SNORM_MIN = 16'h8001;   // -32767

  typedef struct packed {
    logic [31:0] tex_v;
    logic [31:0] tex_u;
    logic        tangent_w_negative;
    logic [15:0] tangent_z;
    logic [15:0] tangent_y;
    logic [15:0] tangent_x;
    logic [15:0] normal_z;
    logic [15:0] normal_y;
    logic [15:0] normal_x;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } in_word_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_t;

  typedef struct packed {
    logic [2:0]  pos_neg;
    logic [2:0]  pos_sat;
    logic [3:0]  oct_neg;
    logic        zero;
    logic [15:0] uv_u;
    logic [15:0] uv_v;
    logic        tneg;
  } meta_t;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? 16'(-v) : v;
  endfunction

endpackage

### hdl/vertex_attribute_quantizer.sv
// Top level of the vertex attribute quantizer: config registers, front end,
// seven divider lanes, side-band delay line and output register.
// Depends on vaq_pkg, vaq_front, vaq_div_lane.
//
//  channel  | ports                  | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_tvalid/tready/tdata | one vertex word per handshake
//  output   | out_tvalid/tready/tdata| one quantized vertex word per handshake
//  config   | cfg_p*  (APB)          | six box registers at 0x00..0x14
//
// The path runs through 3 front-end stages, 16 divider stages (load plus one
// quotient bit per stage, 15 bits) and the output register. One word enters
// per cycle unless stalled; the divider lanes set the depth, not the rate.
// Reset (rst_n low, synchronous) clears all valid bits and the box registers.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage, so nothing is lost or repeated.
module vertex_attribute_quantizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] normal_x,
  // [127:112] normal_y, [143:128] normal_z, [159:144] tangent_x,
  // [175:160] tangent_y, [191:176] tangent_z, [192] tangent_w_negative,
  // [224:193] tex_u, [256:225] tex_v, [263:257] zero
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] qpos_x, [31:16] qpos_y, [47:32] qpos_z, [63:48] qnormal_a,
  // [79:64] qnormal_b, [95:80] qtangent_a, [111:96] qtangent_b,
  // [127:112] qtex_u, [143:128] qtex_v, [145:144] tangent_sign,
  // [146] zero_vector_flag, [151:147] zero
  output logic [151:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [31:0] box_r [vaq_pkg::NUM_REGS];
  logic [vaq_pkg::IDX_W-1:0] cfg_idx;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_hit = cfg_idx < vaq_pkg::IDX_W'(vaq_pkg::NUM_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vaq_pkg::NUM_REGS; i++) box_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      box_r[cfg_idx] <= cfg_pwdata;
    end
  end

  assign cfg_prdata = cfg_hit ? box_r[cfg_idx] : '0;

  // ---------------------------------------------------------------- flow
  // global advance: output register empty or draining this cycle
  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- front
  vaq_pkg::in_word_t in_word;
  assign in_word = in_tdata[256:0];

  logic front_valid;
  vaq_pkg::lane_t [vaq_pkg::NUM_LANES-1:0] lanes;
  vaq_pkg::meta_t front_meta;

  vaq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_word   (in_word),
    .box_min   ({box_r[vaq_pkg::REG_MIN_Z], box_r[vaq_pkg::REG_MIN_Y],
                 box_r[vaq_pkg::REG_MIN_X]}),
    .box_max   ({box_r[vaq_pkg::REG_MAX_Z], box_r[vaq_pkg::REG_MAX_Y],
                 box_r[vaq_pkg::REG_MAX_X]}),
    .out_valid (front_valid),
    .lanes     (lanes),
    .meta      (front_meta)
  );

  // ---------------------------------------------------------------- dividers
  logic [vaq_pkg::NUM_LANES-1:0][vaq_pkg::Q_W-1:0] quot;

  for (genvar l = 0; l < vaq_pkg::NUM_LANES; l++) begin : g_lane
    vaq_div_lane u_div (
      .clk  (clk),
      .en   (en),
      .lane (lanes[l]),
      .quot (quot[l])
    );
  end

  // side band rides alongside the divider stages
  vaq_pkg::meta_t meta_p_r [vaq_pkg::DIV_DEPTH];
  logic [vaq_pkg::DIV_DEPTH-1:0] v_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= '0;
    end else if (en) begin
      v_p_r <= {v_p_r[vaq_pkg::DIV_DEPTH-2:0], front_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_p_r[0] <= front_meta;
      for (int k = 1; k < vaq_pkg::DIV_DEPTH; k++) meta_p_r[k] <= meta_p_r[k-1];
    end
  end

  // ---------------------------------------------------------------- output
  vaq_pkg::meta_t mt;
  logic [vaq_pkg::NUM_LANES-1:0][15:0] sq;
  logic [vaq_pkg::NUM_LANES-1:0] neg;
  logic [151:0] out_nxt, out_r;

  assign mt = meta_p_r[vaq_pkg::DIV_DEPTH-1];
  assign neg = {mt.oct_neg, mt.pos_neg};

  always_comb begin
    for (int l = 0; l < vaq_pkg::NUM_LANES; l++) begin
      sq[l] = neg[l] ? 16'(-{1'b0, quot[l]}) : {1'b0, quot[l]};
    end
    // a position outside the box saturates
    for (int i = 0; i < 3; i++) begin
      if (mt.pos_sat[i]) sq[i] = mt.pos_neg[i] ? vaq_pkg::SNORM_MIN : vaq_pkg::SNORM_MAX;
    end
    out_nxt = {5'b0, mt.zero, mt.tneg ? 2'b11 : 2'b01, mt.uv_v, mt.uv_u,
               sq[vaq_pkg::LANE_TB], sq[vaq_pkg::LANE_TA],
               sq[vaq_pkg::LANE_NB], sq[vaq_pkg::LANE_NA],
               sq[2], sq[1], sq[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_p_r[vaq_pkg::DIV_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r;

  // ---------------------------------------------------------------- checks
  a_sign_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[145:144] == 2'b01 || out_tdata[145:144] == 2'b11))
    else $error("tangent sign is neither +1 nor -1");

  a_snorm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000 &&
                    out_tdata[47:32] != 16'h8000 && out_tdata[63:48] != 16'h8000 &&
                    out_tdata[79:64] != 16'h8000 && out_tdata[95:80] != 16'h8000 &&
                    out_tdata[111:96] != 16'h8000))
    else $error("snorm field reached -32768");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(v_p_r))
    else $error("pipeline moved during stall");

endmodule

### hdl/vaq_front.sv
// Front end: three register stages that form dividend/divisor pairs for the
// divider lanes, plus the uv scaling and side-band flags. Uses vaq_pkg.
module vaq_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  vaq_pkg::in_word_t                      in_word,
  input  logic [2:0][31:0]                       box_min,
  input  logic [2:0][31:0]                       box_max,
  output logic                                   out_valid,
  output vaq_pkg::lane_t [vaq_pkg::NUM_LANES-1:0] lanes,
  output vaq_pkg::meta_t                         meta
);

  logic [2:0][31:0] pos;
  logic [1:0][2:0][15:0] vec;
  logic [1:0][31:0] uv;

  assign pos = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
  assign vec[0] = {in_word.normal_z, in_word.normal_y, in_word.normal_x};
  assign vec[1] = {in_word.tangent_z, in_word.tangent_y, in_word.tangent_x};
  assign uv = {in_word.tex_v, in_word.tex_u};

  // stage A
  logic va_r, vb_r, vc_r;
  logic [2:0][32:0] d_a_r, rng_a_r;
  logic [1:0][2:0][15:0] abs_a_r;
  logic [1:0][2:0] sgn_a_r;
  logic [1:0][47:0] uvp_a_r;
  logic tneg_a_r, tneg_b_r;

  // stage B
  logic [2:0][34:0] mag_b_r;
  logic [2:0] pneg_b_r, rzero_b_r;
  logic [2:0][31:0] rng_b_r;
  logic [1:0][16:0] l1_b_r, ma_b_r, mb_b_r;
  logic [3:0] oneg_b_r;
  logic [1:0] uneg_b_r;
  logic [1:0][47:0] umag_b_r;

  // stage C
  vaq_pkg::lane_t [vaq_pkg::NUM_LANES-1:0] lanes_r;
  vaq_pkg::meta_t meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_a_r[i]   <= {pos[i][31], pos[i]} - {box_min[i][31], box_min[i]};
        rng_a_r[i] <= {box_max[i][31], box_max[i]} - {box_min[i][31], box_min[i]};
      end
      for (int v = 0; v < 2; v++) begin
        for (int c = 0; c < 3; c++) begin
          abs_a_r[v][c] <= vaq_pkg::abs16(vec[v][c]);
          sgn_a_r[v][c] <= vec[v][c][15];
        end
        // t * 32767 = (t << 15) - t
        uvp_a_r[v] <= ({{16{uv[v][31]}}, uv[v]} << 15) - {{16{uv[v][31]}}, uv[v]};
      end
      tneg_a_r <= in_word.tangent_w_negative;
    end
  end

  logic [2:0][34:0] num_b;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_b[i] = {d_a_r[i][32], d_a_r[i], 1'b0} - {{2{rng_a_r[i][32]}}, rng_a_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_b_r[i]   <= num_b[i][34] ? 35'(-num_b[i]) : num_b[i];
        pneg_b_r[i]  <= num_b[i][34];
        rzero_b_r[i] <= rng_a_r[i][32] | (rng_a_r[i] == '0);
        rng_b_r[i]   <= rng_a_r[i][31:0];
      end
      for (int v = 0; v < 2; v++) begin
        l1_b_r[v] <= 17'(abs_a_r[v][0]) + 17'(abs_a_r[v][1]) + 17'(abs_a_r[v][2]);
        // fold into the lower hemisphere when z is negative
        ma_b_r[v] <= sgn_a_r[v][2] ? 17'(abs_a_r[v][0]) + 17'(abs_a_r[v][2])
                                   : 17'(abs_a_r[v][0]);
        mb_b_r[v] <= sgn_a_r[v][2] ? 17'(abs_a_r[v][1]) + 17'(abs_a_r[v][2])
                                   : 17'(abs_a_r[v][1]);
        oneg_b_r[2*v]   <= sgn_a_r[v][0];
        oneg_b_r[2*v+1] <= sgn_a_r[v][1];
        uneg_b_r[v] <= uvp_a_r[v][47];
        umag_b_r[v] <= uvp_a_r[v][47] ? 48'(-uvp_a_r[v]) : uvp_a_r[v];
      end
      tneg_b_r <= tneg_a_r;
    end
  end

  // stage C: dividend = 2*32767*mag + den, divisor = den (doubled in the lane)
  vaq_pkg::lane_t [vaq_pkg::NUM_LANES-1:0] lanes_c;
  logic [2:0] sat_c;
  logic [1:0][15:0] uvq_c;
  logic [1:0][31:0] qm;
  logic [1:0][47:0] qsum;
  logic [3:0][16:0] om;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = !rzero_b_r[i] && (mag_b_r[i] > {3'b000, rng_b_r[i]});
      if (rzero_b_r[i] || sat_c[i]) begin
        lanes_c[i].num = '0;
        lanes_c[i].den = 32'd1;
      end else begin
        lanes_c[i].num = {mag_b_r[i][31:0], 16'h0000}
                       - {15'b0, mag_b_r[i][31:0], 1'b0}
                       + {16'h0000, rng_b_r[i]};
        lanes_c[i].den = rng_b_r[i];
      end
    end
    om = {mb_b_r[1], ma_b_r[1], mb_b_r[0], ma_b_r[0]};
    for (int k = 0; k < 4; k++) begin
      lanes_c[vaq_pkg::LANE_NA + k].num = {15'b0, om[k], 16'h0000}
                                        - {30'b0, om[k], 1'b0}
                                        + {31'b0, l1_b_r[k/2]};
      lanes_c[vaq_pkg::LANE_NA + k].den = (l1_b_r[k/2] == '0) ? 32'd1
                                                              : {15'b0, l1_b_r[k/2]};
    end
    for (int v = 0; v < 2; v++) begin
      qsum[v] = umag_b_r[v] + 48'd32768;
      qm[v] = qsum[v][47:16];
      if (uneg_b_r[v]) begin
        uvq_c[v] = (qm[v] > 32'd32768) ? 16'h8000 : 16'(-qm[v]);
      end else begin
        uvq_c[v] = (qm[v] > 32'd32767) ? 16'h7FFF : qm[v][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r        <= lanes_c;
      meta_r.pos_neg <= pneg_b_r;
      meta_r.pos_sat <= sat_c;
      meta_r.oct_neg <= oneg_b_r;
      meta_r.zero    <= (l1_b_r[0] == '0) | (l1_b_r[1] == '0);
      meta_r.uv_u    <= uvq_c[0];
      meta_r.uv_v    <= uvq_c[1];
      meta_r.tneg    <= tneg_b_r;
    end
  end

  assign out_valid = vc_r;
  assign lanes = lanes_r;
  assign meta = meta_r;

endmodule

### hdl/vaq_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient = floor(num / (2*den)), known to fit 15 bits. Uses vaq_pkg.
module vaq_div_lane (
  input  logic                        clk,
  input  logic                        en,
  input  vaq_pkg::lane_t              lane,
  output logic [vaq_pkg::Q_W-1:0]     quot
);

  logic [vaq_pkg::REM_W-1:0] rem_r [vaq_pkg::DIV_DEPTH];
  logic [vaq_pkg::REM_W-1:0] div_r [vaq_pkg::DIV_DEPTH];
  logic [vaq_pkg::Q_W-1:0]   low_r [vaq_pkg::DIV_DEPTH];
  logic [vaq_pkg::Q_W-1:0]   q_r   [vaq_pkg::DIV_DEPTH];

  // load: top bits of the dividend are already below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= lane.num[vaq_pkg::NUM_W-1:vaq_pkg::Q_W];
      low_r[0] <= lane.num[vaq_pkg::Q_W-1:0];
      div_r[0] <= {lane.den, 1'b0};
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k < vaq_pkg::DIV_DEPTH; k++) begin : g_stage
    logic [vaq_pkg::REM_W:0] trial;
    logic                    ge;
    assign trial = {rem_r[k-1], low_r[k-1][vaq_pkg::Q_W-1]};
    assign ge = trial >= {1'b0, div_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? vaq_pkg::REM_W'(trial - {1'b0, div_r[k-1]})
                       : trial[vaq_pkg::REM_W-1:0];
        low_r[k] <= {low_r[k-1][vaq_pkg::Q_W-2:0], 1'b0};
        div_r[k] <= div_r[k-1];
        q_r[k]   <= {q_r[k-1][vaq_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign quot = q_r[vaq_pkg::DIV_DEPTH-1];

endmodule

### tb/tb.sv
// Self-checking bench for vertex_attribute_quantizer: box registers over APB,
// vertex words on the input stream, quantized words checked against a local predictor.
// Depends on vaq_pkg and the vertex_attribute_quantizer RTL.
module tb;

  localparam int STALL_MAX = 17;
  localparam int WATCHDOG  = 20000;
  localparam int DRAIN_CYC = 40;

  // last member sits in the lowest bits, matching out_tdata
  typedef struct packed {
    logic        zflag;
    logic [1:0]  tsign;
    logic [15:0] qv, qu;
    logic [15:0] qt_b, qt_a, qn_b, qn_a;
    logic [15:0] qpos_z, qpos_y, qpos_x;
  } qvert_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [263:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  vertex_attribute_quantizer DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // box copy used by the predictor
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];

  vaq_pkg::in_word_t vert_q[$];    // vertices waiting to be sent
  qvert_t   quant_q[$];   // predicted words in arrival order
  int n_err = 0, n_sent = 0, n_got = 0, n_zero = 0;
  int idle_cyc = 0;
  bit hold_rx = 0;        // long receiver hold-off request

  // ---------------- predictor ----------------
  // n/d rounded half away from zero, d > 0
  function automatic longint rdiv(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (2 * m + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] axis_q(longint p, longint lo, longint hi);
    longint rng;
    rng = hi - lo;
    if (rng <= 0) return 16'd0;
    return 16'(sat(rdiv(64'sd32767 * (2 * (p - lo) - rng), rng), -32767, 32767));
  endfunction

  // octahedral encode; returns 1 on a zero vector
  function automatic bit octa_q(longint x, longint y, longint z,
                                output logic [15:0] a, output logic [15:0] b);
    longint ax, ay, az, l1, ma, mb;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    l1 = ax + ay + az;
    a = '0;
    b = '0;
    if (l1 == 0) return 1'b1;
    if (z < 0) begin
      // fold into the lower hemisphere
      ma = rdiv(32767 * (ax + az), l1);
      mb = rdiv(32767 * (ay + az), l1);
      a = 16'(x >= 0 ? ma : -ma);
      b = 16'(y >= 0 ? mb : -mb);
    end else begin
      a = 16'(rdiv(32767 * x, l1));
      b = 16'(rdiv(32767 * y, l1));
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] uv_q(longint t);
    return 16'(sat(rdiv(t * 32767, 65536), -32768, 32767));
  endfunction

  function automatic qvert_t quantize(vaq_pkg::in_word_t v);
    qvert_t r;
    bit zn, zt;
    r.qpos_x = axis_q(longint'($signed(v.pos_x)), box_lo[0], box_hi[0]);
    r.qpos_y = axis_q(longint'($signed(v.pos_y)), box_lo[1], box_hi[1]);
    r.qpos_z = axis_q(longint'($signed(v.pos_z)), box_lo[2], box_hi[2]);
    zn = octa_q($signed(v.normal_x), $signed(v.normal_y), $signed(v.normal_z),
                r.qn_a, r.qn_b);
    zt = octa_q($signed(v.tangent_x), $signed(v.tangent_y), $signed(v.tangent_z),
                r.qt_a, r.qt_b);
    r.qu    = uv_q(longint'($signed(v.tex_u)));
    r.qv    = uv_q(longint'($signed(v.tex_v)));
    r.tsign = v.tangent_w_negative ? 2'b11 : 2'b01;
    r.zflag = zn | zt;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    n_err++;
    $display("word %0d: %s got %0d expected %0d", n_got, what, got, want);
  endtask

  task automatic queue_vert(vaq_pkg::in_word_t v);
    vert_q = {vert_q, v};
  endtask

  // ---------------- driver ----------------
  int tx_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        quant_q = {quant_q, quantize(vaq_pkg::in_word_t'(in_tdata[256:0]))};
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          in_tvalid <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (vert_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, vert_q.pop_front()};
          tx_wait   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int rx_wait = 0;
  qvert_t got_w, want_w;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_w = qvert_t'(out_tdata[146:0]);
        if (quant_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want_w = quant_q.pop_front();
          if (got_w.qpos_x != want_w.qpos_x)
            report("qpos_x", $signed(got_w.qpos_x), $signed(want_w.qpos_x));
          if (got_w.qpos_y != want_w.qpos_y)
            report("qpos_y", $signed(got_w.qpos_y), $signed(want_w.qpos_y));
          if (got_w.qpos_z != want_w.qpos_z)
            report("qpos_z", $signed(got_w.qpos_z), $signed(want_w.qpos_z));
          if (got_w.qn_a != want_w.qn_a)
            report("qnormal_a", $signed(got_w.qn_a), $signed(want_w.qn_a));
          if (got_w.qn_b != want_w.qn_b)
            report("qnormal_b", $signed(got_w.qn_b), $signed(want_w.qn_b));
          if (got_w.qt_a != want_w.qt_a)
            report("qtangent_a", $signed(got_w.qt_a), $signed(want_w.qt_a));
          if (got_w.qt_b != want_w.qt_b)
            report("qtangent_b", $signed(got_w.qt_b), $signed(want_w.qt_b));
          if (got_w.qu != want_w.qu)
            report("qtex_u", $signed(got_w.qu), $signed(want_w.qu));
          if (got_w.qv != want_w.qv)
            report("qtex_v", $signed(got_w.qv), $signed(want_w.qv));
          if (got_w.tsign != want_w.tsign)
            report("tangent_sign", $signed(got_w.tsign), $signed(want_w.tsign));
          if (got_w.zflag != want_w.zflag)
            report("zero_vector_flag", got_w.zflag, want_w.zflag);
          if (want_w.zflag) n_zero++;
        end
        n_got++;
      end
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready)
          rx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || hold_rx)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG) begin
      $display("watchdog: no progress, %0d words still expected", quant_q.size());
      $display("vertex_attribute_quantizer: mismatch");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx < 3) box_lo[idx] = val;
    else         box_hi[idx - 3] = val;
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    apb_write(vaq_pkg::REG_MIN_X, lx);
    apb_write(vaq_pkg::REG_MIN_Y, ly);
    apb_write(vaq_pkg::REG_MIN_Z, lz);
    apb_write(vaq_pkg::REG_MAX_X, hx);
    apb_write(vaq_pkg::REG_MAX_Y, hy);
    apb_write(vaq_pkg::REG_MAX_Z, hz);
  endtask

  // wait until every sent vertex came back, then let the pipe settle
  task automatic drain();
    while (vert_q.size() > 0 || in_tvalid || quant_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 262144)) - 131072); // +-2.0
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic vaq_pkg::in_word_t rnd_vert(bit in_box);
    vaq_pkg::in_word_t v;
    v.pos_x = in_box ? box_lo[0] + $urandom_range(0, 65535) * 3 : rnd32();
    v.pos_y = in_box ? box_lo[1] + $urandom_range(0, 65535) * 3 : rnd32();
    v.pos_z = in_box ? box_lo[2] + $urandom_range(0, 65535) * 3 : rnd32();
    v.normal_x = rnd16(); v.normal_y = rnd16(); v.normal_z = rnd16();
    v.tangent_x = rnd16(); v.tangent_y = rnd16(); v.tangent_z = rnd16();
    if ($urandom_range(0, 15) == 0) {v.normal_x, v.normal_y, v.normal_z} = '0;
    if ($urandom_range(0, 15) == 0) {v.tangent_x, v.tangent_y, v.tangent_z} = '0;
    v.tangent_w_negative = $urandom_range(0, 1);
    v.tex_u = rnd32(); v.tex_v = rnd32();
    return v;
  endfunction

  function automatic vaq_pkg::in_word_t mk_vert(logic [31:0] p, logic [15:0] nx, ny, nz,
                                                logic [31:0] t, bit w);
    vaq_pkg::in_word_t v;
    v.pos_x = p; v.pos_y = p; v.pos_z = p;
    v.normal_x = nx; v.normal_y = ny; v.normal_z = nz;
    v.tangent_x = ny; v.tangent_y = nz; v.tangent_z = nx;
    v.tangent_w_negative = w;
    v.tex_u = t; v.tex_v = -t;
    return v;
  endfunction

  // ---------------- main sequence ----------------
  initial begin
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset box is empty on every axis: all positions give zero
    queue_vert(mk_vert(32'h0001_0000, 16'h7fff, 16'h0, 16'h0, 32'h0, 1'b0));
    drain();

    // box [-1,1] on x, degenerate y (max < min), full range on z
    set_box(32'hffff_0000, 32'h0000_0005, 32'h8000_0000,
            32'h0001_0000, 32'h0000_0004, 32'h7fff_ffff);
    queue_vert(mk_vert(32'h0000_0000, 16'h0, 16'h0, 16'h0, 32'h0001_0000, 1'b1));
    queue_vert(mk_vert(32'h7fff_ffff, 16'h8000, 16'h8000, 16'h8000,
                       32'h7fff_ffff, 1'b0));
    queue_vert(mk_vert(32'h8000_0000, 16'h7fff, 16'h7fff, 16'h7fff,
                       32'h8000_0000, 1'b1));
    queue_vert(mk_vert(32'h0000_8000, 16'h0001, 16'hffff, 16'hffff,
                       32'h0000_0001, 1'b0));   // z negative: fold
    queue_vert(mk_vert(32'hffff_8000, 16'hffff, 16'h0001, 16'h0000,
                       32'hffff_ffff, 1'b1));   // z zero: no fold
    queue_vert(mk_vert(32'h0001_0000, 16'h0000, 16'h0000, 16'hc000,
                       32'h0000_8000, 1'b0));   // pure -z
    queue_vert(mk_vert(32'hffff_0000, 16'h0001, 16'h0001, 16'h0001,
                       32'h0000_0002, 1'b1));   // rounding ties region
    queue_vert(mk_vert(32'h0002_0000, 16'h0003, 16'h0000, 16'h0000,
                       32'hfffe_0000, 1'b0));   // above box
    queue_vert(mk_vert(32'hfffe_0000, 16'h0000, 16'h0005, 16'hfffb,
                       32'h0000_4000, 1'b1));   // below box
    drain();

    // random phases over several boxes, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        1: set_box(32'hfff0_0000, 32'h0000_0000, 32'h7fff_fff0,
                   32'h0010_0000, 32'h0000_0001, 32'h7fff_ffff);
        2: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_box(32'hffff_0000, 32'hfffe_0000, 32'h0000_0000,
                         32'h0001_0000, 32'h0003_0000, 32'h0004_0000);
      endcase
      for (int i = 0; i < 200; i++)
        queue_vert(rnd_vert($urandom_range(0, 2) != 0));
      if (ph == 1) begin
        // receiver blocks while sender keeps pushing
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
      drain();
    end

    $display("sent %0d vertices, checked %0d words (%0d with zero vectors)",
             n_sent, n_got, n_zero);
    $display("covered reset box, degenerate and full-range boxes, folds and stalls");
    if (n_err == 0 && quant_q.size() == 0) begin
      $display("vertex_attribute_quantizer: match");
    end else begin
      $display("vertex_attribute_quantizer: mismatch");
    end
    $finish;
  end
endmodule
